[sv/rtc_pkg.sv]
// ----------------------------------------------------------------------------
// Room thermostat controller package
// Shared constants, register indexes, command bundle and fixed-point helpers.
// ----------------------------------------------------------------------------
package rtc_pkg;

  // Field widths.
  localparam int SENSOR_W   = 10;
  localparam int SETPT_W    = 7;
  localparam int MEAS_W     = 10;
  localparam int MODE_W     = 2;
  localparam int TEMP_C_W   = 9;   // Celsius reading, at most 330
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 24;

  // Input beat layout.
  localparam int IN_POWER_BIT  = 0;
  localparam int IN_UNIT_BIT   = 1;
  localparam int IN_MODE_BIT   = 2;
  localparam int IN_UP_BIT     = 3;
  localparam int IN_DOWN_BIT   = 4;
  localparam int IN_SAMPLE_LSB = 5;

  // Sensor scaling: reading times 330 over full scale.
  localparam int SCALE_W = 9;
  localparam int SCALE   = 330;

  // Configuration port.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 7;
  localparam logic [CFG_ADDR_W-1:0] CFG_HIGH_LIMIT_C     = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_LOW_LIMIT_C      = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_HIGH_LIMIT_F     = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_LOW_LIMIT_F      = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_DEFAULT_SETPOINT = 3'd4;

  localparam logic [CFG_DATA_W-1:0] RST_HIGH_LIMIT_C     = 7'd50;
  localparam logic [CFG_DATA_W-1:0] RST_LOW_LIMIT_C      = 7'd15;
  localparam logic [CFG_DATA_W-1:0] RST_HIGH_LIMIT_F     = 7'd122;
  localparam logic [CFG_DATA_W-1:0] RST_LOW_LIMIT_F      = 7'd59;
  localparam logic [CFG_DATA_W-1:0] RST_DEFAULT_SETPOINT = 7'd20;

  // Operating modes.
  localparam logic [MODE_W-1:0] MODE_FAN  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_HEAT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_COOL = 2'd2;
  localparam logic [MODE_W-1:0] MODE_AUTO = 2'd3;

  localparam logic [SETPT_W-1:0] SETPT_MAX = 7'd127;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;   // take the input beat
    logic update;    // apply buttons, first quotient estimate
    logic correct;   // quotient correction
    logic load_out;  // load the result register
  } rtc_cmd_t;

  // floor(y / 5) for y below 4096, by reciprocal multiplication.
  function automatic logic [9:0] div5(input logic [11:0] y);
    logic [23:0] p;
    p = 24'(y) * 24'd3277;
    return p[23:14];
  endfunction

  // floor(y / 9) for y below 512.
  function automatic logic [5:0] div9(input logic [8:0] y);
    logic [20:0] p;
    p = 21'(y) * 21'd3641;
    return p[20:15];
  endfunction

  // Celsius reading to Fahrenheit: floor(c * 9 / 5) + 32.
  function automatic logic [MEAS_W-1:0] c_to_f(input logic [TEMP_C_W-1:0] c);
    logic [11:0] y;
    y = 12'(c) * 12'd9;
    return div5(y) + 10'd32;
  endfunction

  // Setpoint to Fahrenheit, saturated at the top of the setpoint range.
  function automatic logic [SETPT_W-1:0] setpt_to_f(input logic [SETPT_W-1:0] t);
    logic [11:0] y;
    logic [9:0]  v;
    y = 12'(t) * 12'd9;
    v = div5(y) + 10'd32;
    return (v > 10'(SETPT_MAX)) ? SETPT_MAX : v[SETPT_W-1:0];
  endfunction

  // Setpoint to Celsius, zero at or below freezing.
  function automatic logic [SETPT_W-1:0] setpt_to_c(input logic [SETPT_W-1:0] t);
    logic [8:0] y;
    y = 9'(t - 7'd32) * 9'd5;
    return (t <= 7'd32) ? '0 : 7'(div9(y));
  endfunction

endpackage

[sv/rtc_ctrl.sv]
// ----------------------------------------------------------------------------
// Room thermostat controller sequencer
// Steps one tick through capture, update, correction and result load.
// ----------------------------------------------------------------------------
module rtc_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  output logic             out_tvalid,
  input  logic             out_tready,
  output rtc_pkg::rtc_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_UPD  = 2'd1;
  localparam logic [1:0] S_COR  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_UPD;
        end
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_nxt  = S_COR;
      end
      S_COR: begin
        cmd.correct = 1'b1;
        state_nxt   = S_FIN;
      end
      S_FIN: begin
        // The result register is free, or its beat leaves this cycle.
        if (!out_valid_r || out_tready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  a_tick_reaches_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |-> ##3 (state_r == S_FIN))
    else $error("accepted beat did not reach the final step on time");

  a_free_slot_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && !out_valid_r) |=> (out_valid_r && state_r == S_IDLE))
    else $error("result not loaded into a free output register");

  a_valid_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_FIN))
    else $error("output valid raised outside the final step");

endmodule

[sv/rtc_datapath.sv]
// ----------------------------------------------------------------------------
// Room thermostat controller datapath
// Holds configuration and controller state, scales the sensor reading and
// forms the drive decisions and the result beat.
// ----------------------------------------------------------------------------
module rtc_datapath #(
  parameter int SAMPLE_BITS = 10
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  rtc_pkg::rtc_cmd_t                   cmd,
  input  logic [rtc_pkg::IN_DATA_W-1:0]       in_tdata,
  input  logic                                cfg_wen,
  input  logic [rtc_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [rtc_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  output logic [rtc_pkg::OUT_DATA_W-1:0]      out_tdata
);

  localparam int SW = (SAMPLE_BITS < rtc_pkg::SENSOR_W) ? SAMPLE_BITS : rtc_pkg::SENSOR_W;
  localparam int XW = SW + rtc_pkg::SCALE_W;
  localparam int PW = 2 * XW;
  localparam int CW = rtc_pkg::TEMP_C_W + SAMPLE_BITS;
  localparam longint FS    = (longint'(1) << SAMPLE_BITS) - 1;
  localparam longint RECIP = (longint'(1) << XW) / FS;

  localparam int CW_T = rtc_pkg::TEMP_C_W;
  localparam int SP_W = rtc_pkg::SETPT_W;

  // Configuration registers.
  logic [SP_W-1:0] hi_c_r, lo_c_r, hi_f_r, lo_f_r, def_sp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hi_c_r   <= rtc_pkg::RST_HIGH_LIMIT_C;
      lo_c_r   <= rtc_pkg::RST_LOW_LIMIT_C;
      hi_f_r   <= rtc_pkg::RST_HIGH_LIMIT_F;
      lo_f_r   <= rtc_pkg::RST_LOW_LIMIT_F;
      def_sp_r <= rtc_pkg::RST_DEFAULT_SETPOINT;
    end else if (cfg_wen) begin
      case (cfg_addr)
        rtc_pkg::CFG_HIGH_LIMIT_C:     hi_c_r   <= cfg_wdata;
        rtc_pkg::CFG_LOW_LIMIT_C:      lo_c_r   <= cfg_wdata;
        rtc_pkg::CFG_HIGH_LIMIT_F:     hi_f_r   <= cfg_wdata;
        rtc_pkg::CFG_LOW_LIMIT_F:      lo_f_r   <= cfg_wdata;
        rtc_pkg::CFG_DEFAULT_SETPOINT: def_sp_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Captured beat: buttons and the scaled sample.
  logic [4:0]    btn_r;
  logic [XW-1:0] x_r, x_nxt;
  logic [SW-1:0] sample;

  assign sample = in_tdata[rtc_pkg::IN_SAMPLE_LSB +: SW];
  assign x_nxt  = XW'(sample) * XW'(rtc_pkg::SCALE);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      btn_r <= in_tdata[rtc_pkg::IN_DOWN_BIT:rtc_pkg::IN_POWER_BIT];
      x_r   <= x_nxt;
    end
  end

  // Controller state and button handling.
  logic                       powered_r, powered_nxt;
  logic                       fahr_r, fahr_nxt;
  logic [rtc_pkg::MODE_W-1:0] mode_r, mode_nxt;
  logic [SP_W-1:0]            sp_r, sp_nxt;

  always_comb begin
    logic [SP_W-1:0] sp1, sp2, hi, lo;
    powered_nxt = powered_r ^ btn_r[rtc_pkg::IN_POWER_BIT];
    fahr_nxt    = 1'b0;
    mode_nxt    = rtc_pkg::MODE_FAN;
    sp_nxt      = def_sp_r;
    sp1         = sp_r;
    sp2         = sp_r;
    hi          = hi_c_r;
    lo          = lo_c_r;
    if (powered_nxt) begin
      fahr_nxt = fahr_r ^ btn_r[rtc_pkg::IN_UNIT_BIT];
      if (btn_r[rtc_pkg::IN_UNIT_BIT]) begin
        sp1 = fahr_nxt ? rtc_pkg::setpt_to_f(sp_r) : rtc_pkg::setpt_to_c(sp_r);
      end
      mode_nxt = mode_r + rtc_pkg::MODE_W'(btn_r[rtc_pkg::IN_MODE_BIT]);
      hi = fahr_nxt ? hi_f_r : hi_c_r;
      lo = fahr_nxt ? lo_f_r : lo_c_r;
      sp2 = sp1;
      if (btn_r[rtc_pkg::IN_UP_BIT] && sp1 <= hi && sp1 != rtc_pkg::SETPT_MAX) begin
        sp2 = sp1 + 7'd1;
      end
      sp_nxt = sp2;
      if (btn_r[rtc_pkg::IN_DOWN_BIT] && sp2 > lo) begin
        sp_nxt = sp2 - 7'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      powered_r <= 1'b0;
      fahr_r    <= 1'b0;
      mode_r    <= rtc_pkg::MODE_FAN;
      sp_r      <= rtc_pkg::RST_DEFAULT_SETPOINT;
    end else if (cmd.update) begin
      powered_r <= powered_nxt;
      fahr_r    <= fahr_nxt;
      mode_r    <= mode_nxt;
      sp_r      <= sp_nxt;
    end
  end

  // Division by full scale: reciprocal estimate, then one correction.
  logic [PW-1:0]   prod;
  logic [CW_T-1:0] q0_r, c_r;
  logic [CW-1:0]   qfs, rem;

  assign prod = PW'(x_r) * PW'(RECIP);
  assign qfs  = (CW'(q0_r) << SAMPLE_BITS) - CW'(q0_r);
  assign rem  = CW'(x_r) - qfs;

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      q0_r <= CW_T'(prod >> XW);
    end
    if (cmd.correct) begin
      c_r <= q0_r + CW_T'(rem >= CW'(FS));
    end
  end

  // Measured temperature and drives.
  logic [rtc_pkg::MEAS_W-1:0] meas;
  logic                       heat, cool, fan, above, below;

  assign meas  = fahr_r ? rtc_pkg::c_to_f(c_r) : rtc_pkg::MEAS_W'(c_r);
  assign above = rtc_pkg::MEAS_W'(sp_r) > meas;
  assign below = rtc_pkg::MEAS_W'(sp_r) < meas;

  always_comb begin
    heat = 1'b0;
    cool = 1'b0;
    fan  = 1'b0;
    if (powered_r) begin
      case (mode_r)
        rtc_pkg::MODE_FAN: begin
          fan = 1'b1;
        end
        rtc_pkg::MODE_HEAT: begin
          heat = above;
          fan  = above;
        end
        rtc_pkg::MODE_COOL: begin
          cool = below;
          fan  = below;
        end
        default: begin
          heat = above;
          cool = below;
          fan  = above || below;
        end
      endcase
    end
  end

  logic [rtc_pkg::OUT_DATA_W-1:0] out_data_r;

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r <= {powered_r, fahr_r, mode_r, meas, sp_r, fan, cool, heat};
    end
  end

  assign out_tdata = out_data_r;

  a_off_is_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    !powered_r |-> (mode_r == rtc_pkg::MODE_FAN && !fahr_r))
    else $error("mode or unit not cleared while powered off");

  a_off_no_drive: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> (out_data_r[rtc_pkg::OUT_DATA_W-1] || out_data_r[2:0] == 3'b000))
    else $error("drive active in a result beat while powered off");

endmodule

[sv/room_thermostat_controller_top.sv]
// ----------------------------------------------------------------------------
// Room thermostat controller, top level
//
// One input beat is one tick: five button presses and a sensor reading. The
// block answers each tick with exactly one result beat carrying the heater,
// cooler and fan drives, the setpoint and measured temperature in the chosen
// unit, the mode, the unit and the power status.
// A tick passes these steps from acceptance to the result register: capture
// (the sample is scaled by 330 on the way in), state update with a first
// reciprocal estimate of the division by full scale, one correction step,
// and the final unit conversion and drive decision. A new tick is taken on
// the cycle after the result is loaded, so the block takes no new tick while
// an earlier one is still in its steps.
// The result sits in a register of its own, so a tick may be accepted while
// an earlier result still waits; if the receiver stalls, the following tick
// holds in its last step until the register is free.
// After reset the unit is off, in Celsius and fan mode, with the default
// setpoint, and the limit registers hold their documented defaults.
// Configuration writes take effect on the clock edge that carries them.
// ----------------------------------------------------------------------------
module room_thermostat_controller_top #(
  parameter int SAMPLE_BITS = 10
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // in_tdata: power_press, unit_press, mode_press, up_press, down_press,
  // sensor_sample[9:0], one zero bit.
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [rtc_pkg::IN_DATA_W-1:0]  in_tdata,
  // out_tdata: heater_on, cooler_on, fan_on, setpoint_out[6:0],
  // measured_temp[9:0], mode_out[1:0], fahrenheit_out, powered_out.
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [rtc_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                           cfg_wen,
  input  logic [rtc_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [rtc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  // Command bundle from the sequencer to the datapath.
  rtc_pkg::rtc_cmd_t cmd;

  // The sequencer owns the handshakes and the result valid flag.
  rtc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  // The datapath holds the settings, the controller state and the result.
  rtc_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_tdata  (in_tdata),
    .cfg_wen   (cfg_wen),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .out_tdata (out_tdata)
  );

endmodule
